// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/facd_pkg.sv -----
// shared types and constants for the framed ascii command decoder
// no dependencies
package facd_pkg;

	localparam int BUFFER_DEPTH_DEF = 16;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_W      = 8'h57;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_Q      = 8'h51;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// first and last store positions that decoding ever looks at
	localparam int FIRST_USED_POS = 1;
	localparam int LAST_USED_POS  = 9;

	typedef enum logic [2:0] {
		KIND_PULSE  = 3'd0,
		KIND_ANGLE  = 3'd1,
		KIND_SETALL = 3'd2,
		KIND_QUERY  = 3'd3,
		KIND_ACTION = 3'd4,
		KIND_BAD    = 3'd5
	} kind_t;

endpackage

// ----- rtl/framed_ascii_command_decoder_core.sv -----
// top level of the framed ascii command decoder
// depends on facd_pkg and assert_macros.svh
`include "assert_macros.svh"

// Framed ASCII command decoder. Takes one received byte per transfer on the
// input channel and emits one decoded command (kind, motor_id, value) for every
// '#' byte. A '$' moves the write position back to 0; every byte is stored at
// the write position, which then advances (a '#' returns it to 0) and saturates
// at BUFFER_DEPTH (bytes beyond that are dropped). Decoding reads store positions
// 1 to 9, which may hold bytes left from earlier commands; digits are unchecked.
// Rate: one byte per cycle, sustained while the output is not stalled, including
// back-to-back '#' bytes. The byte is written into the store at its transfer
// edge, where a '#' also sets a one bit decode stage; the combinational decode
// of the store is then captured from that stage in the output register, which
// drives out_valid.
// Only positions 1 to 9 are kept in flip-flops (cleared by reset);
// the other positions are never read and need only the write position count.
// The input stalls only when the decode stage is occupied and the output
// register is full and stalled.
module framed_ascii_command_decoder_core
	import facd_pkg::*;
#(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic signed [12:0] motor_id,
	output logic signed [18:0] value
);

	localparam int POS_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(BUFFER_DEPTH);

	// write position and the kept part of the line store
	logic [POS_W-1:0] pos_q;
	logic [7:0]       store_q [FIRST_USED_POS:LAST_USED_POS];

	// decode stage: a '#' has been stored and waits to be decoded
	logic s1_valid_s1;

	// output register
	logic               out_valid_q;
	kind_t              kind_q;
	logic signed [12:0] motor_q;
	logic signed [18:0] value_q;

	logic             in_xfer;
	logic             s1_advance;
	logic             is_hash;
	logic [POS_W-1:0] wr_pos;
	logic             wr_ok;
	logic [POS_W-1:0] pos_next;

	kind_t              kind_d;
	logic signed [12:0] motor_d;
	logic signed [18:0] value_d;

	// byte minus '0', as a signed value
	function automatic logic signed [8:0] digit(input logic [7:0] b);
		return $signed({1'b0, b}) - $signed({1'b0, CH_ZERO});
	endfunction

	// handshake: the decode stage moves on unless the output is full and stalled
	assign s1_advance = !(out_valid_q && out_stall);
	assign in_stall   = s1_valid_s1 && !s1_advance;
	assign in_xfer    = in_valid && !in_stall;
	assign is_hash    = (rx_byte == CH_HASH);

	// '$' restarts the line before it is itself stored
	assign wr_pos = (rx_byte == CH_DOLLAR) ? '0 : pos_q;
	assign wr_ok  = (wr_pos < DEPTH_POS);

	always_comb begin
		if (is_hash) begin
			pos_next = '0;
		end else if (wr_ok) begin
			pos_next = wr_pos + POS_W'(1);
		end else begin
			pos_next = wr_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_xfer) begin
			pos_q <= pos_next;
		end
	end

	// one register per kept position, each with its own fixed address match
	for (genvar i = FIRST_USED_POS; i <= LAST_USED_POS; i++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[i] <= '0;
			end else if (in_xfer && wr_ok && (wr_pos == POS_W'(i))) begin
				store_q[i] <= rx_byte;
			end
		end
	end

	// decode stage loads whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_xfer && is_hash;
		end
	end

	// decode of the store as it stands after the '#' was written
	always_comb begin
		kind_d  = KIND_BAD;
		motor_d = '0;
		value_d = '0;
		priority if (store_q[1] == CH_M && store_q[4] == CH_W && store_q[9] == CH_HASH) begin
			kind_d  = KIND_PULSE;
			motor_d = 13'(digit(store_q[2])) * 13'sd10 + 13'(digit(store_q[3]));
			value_d = 19'(digit(store_q[5])) * 19'sd1000
			        + 19'(digit(store_q[6])) * 19'sd100
			        + 19'(digit(store_q[7])) * 19'sd10
			        + 19'(digit(store_q[8]));
		end else if (store_q[1] == CH_M && store_q[4] == CH_A && store_q[8] == CH_HASH) begin
			kind_d  = KIND_ANGLE;
			motor_d = 13'(digit(store_q[2])) * 13'sd10 + 13'(digit(store_q[3]));
			value_d = 19'(digit(store_q[5])) * 19'sd100
			        + 19'(digit(store_q[6])) * 19'sd10
			        + 19'(digit(store_q[7]));
		end else if (store_q[1] == CH_S && store_q[5] == CH_HASH) begin
			kind_d  = KIND_SETALL;
			value_d = 19'(digit(store_q[2])) * 19'sd100
			        + 19'(digit(store_q[3])) * 19'sd10
			        + 19'(digit(store_q[4]));
		end else if (store_q[1] == CH_Q && store_q[2] == CH_HASH) begin
			kind_d = KIND_QUERY;
		end else if (store_q[1] == CH_A && store_q[3] == CH_HASH) begin
			kind_d  = KIND_ACTION;
			value_d = 19'(digit(store_q[2]));
		end else begin
			kind_d = KIND_BAD;
		end
	end

	// output register: loads whenever it is empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_valid_s1) begin
			kind_q  <= kind_d;
			motor_q <= motor_d;
			value_q <= value_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign motor_id  = motor_q;
	assign value     = value_q;

	// write position saturates at the store depth
	`ASSERT_NEVER(a_pos_range, clk, arst_n, pos_q > DEPTH_POS, "write position beyond depth")
	// a stored '#' always reaches the decode stage and restarts the line
	`ASSERT_ALWAYS(a_hash_decode, clk, arst_n, (in_xfer && is_hash) |=> (s1_valid_s1 && pos_q == '0), "hash transfer not decoded")
	// a waiting decode blocks any store update
	`ASSERT_ALWAYS(a_hold_store, clk, arst_n, (s1_valid_s1 && !s1_advance) |-> in_stall, "store may change under a pending decode")
	// a pending decode moves into a free output register
	`ASSERT_ALWAYS(a_out_load, clk, arst_n, (s1_valid_s1 && !out_valid_q) |=> out_valid_q, "decode result lost")

endmodule

// ----- tb/sv/framed_ascii_command_decoder_core_tb.sv -----
// self-checking testbench for framed_ascii_command_decoder_core
// depends on facd_pkg and the rtl; a scoreboard class predicts every decoded command
// directed frames first, then random frames, noise and overlong lines under random stalls

module framed_ascii_command_decoder_core_tb;
	import facd_pkg::*;

	localparam int BYTE_TARGET = 2000;

	// one decoded command as it should leave the block
	typedef struct {
		kind_t                kind;
		logic signed [12:0]   motor;
		logic signed [18:0]   value;
	} decoded_cmd_t;

	// shadow of the line store plus the queue of commands still owed by the block
	class command_scoreboard;
		bit [7:0]       line_store [BUFFER_DEPTH_DEF];
		int unsigned    write_pos;
		decoded_cmd_t   pending_cmds [$];
		int unsigned    errors;

		function new();
			foreach (line_store[i]) line_store[i] = 8'h00;
			write_pos = 0;
			errors = 0;
		endfunction

		// unchecked ascii digit, may go negative or far above nine
		function int digit_at(int pos);
			return int'(line_store[pos]) - int'(CH_ZERO);
		endfunction

		// called once per accepted input transfer
		function void note_byte(bit [7:0] b);
			decoded_cmd_t cmd;
			int m;
			int v;
			if (b == CH_DOLLAR) write_pos = 0;
			// position saturates once the store is full, later bytes are dropped
			if (write_pos < BUFFER_DEPTH_DEF) begin
				line_store[write_pos] = b;
				write_pos++;
			end
			if (b != CH_HASH) return;
			m = 0;
			v = 0;
			// first match wins; stale bytes from older lines take part as they are
			if (line_store[1] == CH_M && line_store[4] == CH_W && line_store[9] == CH_HASH) begin
				cmd.kind = KIND_PULSE;
				m = digit_at(2) * 10 + digit_at(3);
				v = digit_at(5) * 1000 + digit_at(6) * 100 + digit_at(7) * 10 + digit_at(8);
			end else if (line_store[1] == CH_M && line_store[4] == CH_A
					&& line_store[8] == CH_HASH) begin
				cmd.kind = KIND_ANGLE;
				m = digit_at(2) * 10 + digit_at(3);
				v = digit_at(5) * 100 + digit_at(6) * 10 + digit_at(7);
			end else if (line_store[1] == CH_S && line_store[5] == CH_HASH) begin
				cmd.kind = KIND_SETALL;
				v = digit_at(2) * 100 + digit_at(3) * 10 + digit_at(4);
			end else if (line_store[1] == CH_Q && line_store[2] == CH_HASH) begin
				cmd.kind = KIND_QUERY;
			end else if (line_store[1] == CH_A && line_store[3] == CH_HASH) begin
				cmd.kind = KIND_ACTION;
				v = digit_at(2);
			end else begin
				cmd.kind = KIND_BAD;
			end
			cmd.motor = 13'(m);
			cmd.value = 19'(v);
			write_pos = 0;
			pending_cmds.push_back(cmd);
		endfunction

		// called once per accepted output transfer
		function void check_result(logic [2:0] k, logic signed [12:0] mid,
				logic signed [18:0] val);
			decoded_cmd_t want;
			if (pending_cmds.size() == 0) begin
				if (errors < 10)
					$display("unexpected command: kind %0d motor %0d value %0d",
						k, mid, val);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			if (k !== want.kind || mid !== want.motor || val !== want.value) begin
				if (errors < 10)
					$display("command mismatch: expected kind %0d motor %0d value %0d, got kind %0d motor %0d value %0d",
						want.kind, want.motor, want.value, k, mid, val);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               in_valid = 1'b0;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [2:0]         kind;
	logic signed [12:0] motor_id;
	logic signed [18:0] value;

	command_scoreboard  sb;
	// while set, neither side idles or stalls
	bit                 calm = 1'b0;
	int unsigned        bytes_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	framed_ascii_command_decoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.motor_id  (motor_id),
		.value     (value)
	);

	// idle with a chance of roughly 29 in a hundred, never during the calm stretch
	function automatic bit idle_roll();
		return !calm && ($urandom_range(99) < 29);
	endfunction

	// mostly ascii digits, sometimes the byte extremes or anything at all
	function automatic logic [7:0] rand_digit();
		int r;
		r = $urandom_range(99);
		if (r < 85) return 8'(int'(CH_ZERO) + $urandom_range(9));
		if (r < 90) return 8'h00;
		if (r < 95) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] rand_letter();
		case ($urandom_range(5))
			0: return CH_M;
			1: return CH_W;
			2: return CH_A;
			3: return CH_S;
			4: return CH_Q;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// result side: check each transfer, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(kind, motor_id, value);
			out_stall <= idle_roll();
		end
	end

	// one input transfer; the payload holds while the block stalls
	task automatic send_byte(input logic [7:0] b);
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// sender holds off until every owed command has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
	endtask

	// one random line: mostly well formed, the rest broken, overlong or noise
	task automatic send_random_frame();
		logic [7:0] q [$];
		logic [7:0] fill;
		int pick;
		int n;
		pick = $urandom_range(99);
		if (pick < 65) begin
			q.push_back(CH_DOLLAR);
			case ($urandom_range(4))
				0: q = {q, CH_M, rand_digit(), rand_digit(), CH_W,
					rand_digit(), rand_digit(), rand_digit(), rand_digit()};
				1: q = {q, CH_M, rand_digit(), rand_digit(), CH_A,
					rand_digit(), rand_digit(), rand_digit()};
				2: q = {q, CH_S, rand_digit(), rand_digit(), rand_digit()};
				3: q.push_back(CH_Q);
				default: q = {q, CH_A, rand_digit()};
			endcase
			// now and then cut the line short so the next one lands on leftovers
			if ($urandom_range(19) != 0) q.push_back(CH_HASH);
		end else if (pick < 75) begin
			// overlong line fills the store, the terminator arrives while saturated
			q.push_back(CH_DOLLAR);
			n = $urandom_range(BUFFER_DEPTH_DEF, BUFFER_DEPTH_DEF + 6);
			for (int i = 0; i < n; i++) begin
				fill = (i == 0) ? rand_letter() : rand_digit();
				if (fill == CH_DOLLAR || fill == CH_HASH) fill = CH_W;
				q.push_back(fill);
			end
			q.push_back(CH_HASH);
		end else if (pick < 85) begin
			// odd header or length, sometimes with no start marker at all
			if ($urandom_range(1)) q.push_back(CH_DOLLAR);
			q.push_back(rand_letter());
			n = $urandom_range(9);
			for (int i = 0; i < n; i++) q.push_back(rand_digit());
			q.push_back(CH_HASH);
		end else begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
		end
		foreach (q[i]) send_byte(q[i]);
	endtask

	initial begin
		sb = new();
		// falling edge at time zero so the asynchronous reset takes effect
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: every command kind, byte extremes in digit slots, reuse of stale bytes
		send_text("$Q#");
		send_text("$A7#");
		send_byte(CH_DOLLAR);
		send_byte(CH_S);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_HASH);
		send_text("$M99W9999#");
		// lone terminator decodes the previous pulse line again
		send_byte(CH_HASH);
		send_text("$M00A000#");
		send_text("$Z#");

		// pressure: hold the sender until the block has caught up
		wait_drained();

		while (bytes_sent < BYTE_TARGET) begin
			calm = (bytes_sent >= 800 && bytes_sent < 1100);
			send_random_frame();
		end
		calm = 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_cmds.size() == 0)
			$display("framed_ascii_command_decoder_core_tb passed");
		else
			$display("framed_ascii_command_decoder_core_tb failed");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("framed_ascii_command_decoder_core_tb failed");
		$finish;
	end

endmodule
